// File: hdl/mlr_pkg.sv
// Package for the midpoint line rasterizer: widths, payload structs and the
// command format that runs from the front stage through the queue to the back.
// No dependencies.
`timescale 1ns / 1ps

package mlr_pkg;

    // Field widths.
    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 24;
    // The decision value spans -2*max .. +2*max, so two more bits and a sign.
    localparam int DEC_BITS    = COORD_BITS + 3;
    // The command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    // Input item codes.
    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    // One input item.
    typedef struct packed {
        action_t action;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
        color_t  pixel_color;
    } in_item_t;

    // One result item.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t out_color;
        logic   final_pixel;
        logic   pixel_valid;
    } out_item_t;

    // Octant of a line: ymajor is the low bit of the packed value.
    typedef struct packed {
        logic ydown;
        logic xdown;
        logic ymajor;
    } octant_t;

    // Classified command handed from the front stage to the back stage.
    typedef struct packed {
        logic                          is_start;
        octant_t                       octant;
        logic signed [DEC_BITS-1:0]    dec_init;
        logic [COORD_BITS:0]           inc_axial;
        logic signed [COORD_BITS+1:0]  inc_diag;
        coord_t                        stop_major;
        coord_t                        first_x;
        coord_t                        first_y;
        color_t                        color;
        logic                          active;
    } line_cmd_t;

endpackage

// File: hdl/mlr_front.sv
// Front stage of the line rasterizer: accepts input items, classifies them and
// works out the octant, decision value and increments of a new line.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mlr_pkg::in_item_t item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output mlr_pkg::line_cmd_t cmd
);
    import mlr_pkg::*;

    logic                         front_valid_reg;
    logic                         front_valid_next;
    line_cmd_t                    cmd_reg;
    line_cmd_t                    cmd_next;

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]          adx_wide;
    logic [COORD_BITS:0]          ady_wide;
    coord_t                       adx;
    coord_t                       ady;
    logic                         ymajor;
    coord_t                       dmaj;
    coord_t                       dmin;
    logic                         take;

    // The stage is free when empty or when its command moves on this cycle.
    assign item_ready = !front_valid_reg || cmd_ready;
    assign take       = item_valid && item_ready;
    assign cmd_valid  = front_valid_reg;
    assign cmd        = cmd_reg;

    // Line setup: deltas, octant and the midpoint terms.
    always_comb
    begin
        dx       = $signed({1'b0, item.end_x}) - $signed({1'b0, item.start_x});
        dy       = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
        adx_wide = dx[COORD_BITS] ? (COORD_BITS + 1)'(0) - dx : dx;
        ady_wide = dy[COORD_BITS] ? (COORD_BITS + 1)'(0) - dy : dy;
        adx      = adx_wide[COORD_BITS-1:0];
        ady      = ady_wide[COORD_BITS-1:0];
        ymajor   = adx < ady;
        dmaj     = ymajor ? ady : adx;
        dmin     = ymajor ? adx : ady;

        cmd_next               = cmd_reg;
        cmd_next.is_start      = (item.action == ACT_START);
        cmd_next.octant.ymajor = ymajor;
        cmd_next.octant.xdown  = dx[COORD_BITS];
        cmd_next.octant.ydown  = dy[COORD_BITS];
        cmd_next.dec_init      = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        cmd_next.inc_axial     = {dmin, 1'b0};
        cmd_next.inc_diag      = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
        cmd_next.stop_major    = ymajor ? item.end_y : item.end_x;
        cmd_next.first_x       = item.start_x;
        cmd_next.first_y       = item.start_y;
        cmd_next.color         = item.pixel_color;
        cmd_next.active        = (dmaj != '0);
    end

    // Occupancy of the stage.
    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Command payload, loaded on each transfer.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// File: hdl/mlr_queue.sv
// Short register based command queue between front and back stages of the
// rasterizer; one push (unless full), one pop per cycle. Uses mlr_pkg.
`timescale 1ns / 1ps

module mlr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mlr_pkg::line_cmd_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mlr_pkg::line_cmd_t pop_data
);
    import mlr_pkg::*;

    localparam logic [QUEUE_AW-1:0] PTR_ONE = QUEUE_AW'(1);
    localparam logic [QUEUE_AW:0]   CNT_ONE = (QUEUE_AW + 1)'(1);
    localparam logic [QUEUE_AW:0]   CNT_MAX = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    line_cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_next;
    logic [QUEUE_AW:0]      count_reg;
    logic [QUEUE_AW:0]      count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != CNT_MAX);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    // The fill count never runs past the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("queue count beyond depth");
`endif

endmodule

// File: hdl/mlr_back.sv
// Back stage of the line rasterizer: holds the line state, executes start and
// advance commands one per cycle unless the output is stalled, and registers
// the resulting pixel. Depends on mlr_pkg.
`timescale 1ns / 1ps

module mlr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mlr_pkg::line_cmd_t cmd,
    output logic               result_valid,
    input  logic               result_ready,
    output mlr_pkg::out_item_t result
);
    import mlr_pkg::*;

    // Line state.
    coord_t                        cur_x_reg;
    coord_t                        cur_x_next;
    coord_t                        cur_y_reg;
    coord_t                        cur_y_next;
    coord_t                        stop_major_reg;
    coord_t                        stop_major_next;
    logic signed [DEC_BITS-1:0]    dec_reg;
    logic signed [DEC_BITS-1:0]    dec_next;
    logic [COORD_BITS:0]           inc_axial_reg;
    logic [COORD_BITS:0]           inc_axial_next;
    logic signed [COORD_BITS+1:0]  inc_diag_reg;
    logic signed [COORD_BITS+1:0]  inc_diag_next;
    octant_t                       octant_reg;
    octant_t                       octant_next;
    color_t                        color_reg;
    color_t                        color_next;
    logic                          line_active_reg;
    logic                          line_active_next;

    // Output register.
    logic                          result_valid_reg;
    logic                          result_valid_next;
    out_item_t                     result_reg;
    out_item_t                     result_next;

    // Step datapath.
    logic                          diag;
    logic signed [DEC_BITS-1:0]    dec_add;
    coord_t                        x_step;
    coord_t                        y_step;
    coord_t                        step_x;
    coord_t                        step_y;
    coord_t                        major;
    logic                          hit;
    logic                          take;

    assign cmd_ready    = !result_valid_reg || result_ready;
    assign take         = cmd_valid && cmd_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // One midpoint step from the current state.
    always_comb
    begin
        diag    = !dec_reg[DEC_BITS-1] && (dec_reg != '0);
        dec_add = diag ? {inc_diag_reg[COORD_BITS+1], inc_diag_reg}
                       : $signed({2'b00, inc_axial_reg});
        x_step  = octant_reg.xdown ? cur_x_reg - COORD_BITS'(1)
                                   : cur_x_reg + COORD_BITS'(1);
        y_step  = octant_reg.ydown ? cur_y_reg - COORD_BITS'(1)
                                   : cur_y_reg + COORD_BITS'(1);
        if (octant_reg.ymajor)
        begin
            step_y = y_step;
            step_x = diag ? x_step : cur_x_reg;
            major  = y_step;
        end
        else
        begin
            step_x = x_step;
            step_y = diag ? y_step : cur_y_reg;
            major  = x_step;
        end
        hit = (major == stop_major_reg);
    end

    // Next state and next result.
    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        stop_major_next   = stop_major_reg;
        dec_next          = dec_reg;
        inc_axial_next    = inc_axial_reg;
        inc_diag_next     = inc_diag_reg;
        octant_next       = octant_reg;
        color_next        = color_reg;
        line_active_next  = line_active_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        if (take)
        begin
            result_valid_next = 1'b1;
            if (cmd.is_start)
            begin
                cur_x_next       = cmd.first_x;
                cur_y_next       = cmd.first_y;
                stop_major_next  = cmd.stop_major;
                dec_next         = cmd.dec_init;
                inc_axial_next   = cmd.inc_axial;
                inc_diag_next    = cmd.inc_diag;
                octant_next      = cmd.octant;
                color_next       = cmd.color;
                line_active_next = cmd.active;
                result_next.pixel_x     = cmd.first_x;
                result_next.pixel_y     = cmd.first_y;
                result_next.out_color   = cmd.color;
                result_next.final_pixel = !cmd.active;
                result_next.pixel_valid = 1'b1;
            end
            else if (!line_active_reg)
            begin
                // Advance with no line in progress.
                result_next = '0;
            end
            else
            begin
                cur_x_next       = step_x;
                cur_y_next       = step_y;
                dec_next         = dec_reg + dec_add;
                line_active_next = !hit;
                result_next.pixel_x     = step_x;
                result_next.pixel_y     = step_y;
                result_next.out_color   = color_reg;
                result_next.final_pixel = hit;
                result_next.pixel_valid = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            line_active_reg  <= line_active_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        stop_major_reg <= stop_major_next;
        dec_reg        <= dec_next;
        inc_axial_reg  <= inc_axial_next;
        inc_diag_reg   <= inc_diag_next;
        octant_reg     <= octant_next;
        color_reg      <= color_next;
        result_reg     <= result_next;
    end

`ifndef ASSERT_OFF
    // A start leaves a line active exactly when it has length.
    a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.is_start) |=> (line_active_reg == $past(cmd.active)))
        else $error("line activity wrong after start");

    // Reaching the endpoint on the major axis ends the line.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cmd.is_start && line_active_reg && hit)
            |=> (!line_active_reg && result_reg.final_pixel))
        else $error("endpoint did not end the line");

    // An invalid pixel carries all-zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.pixel_valid)
            |-> (result_reg.pixel_x == '0 && result_reg.pixel_y == '0
                 && result_reg.out_color == '0 && !result_reg.final_pixel))
        else $error("invalid pixel with nonzero fields");
`endif

endmodule

// File: hdl/midpoint_line_rasterizer.sv
// Path: an input item is held in the front register, then the command queue,
// then the output register, where its result becomes valid.
// Throughput: one item per cycle while results are taken; each pixel step
// is one add and compare on the registered line state in the back stage.
// Reset: asynchronous, active low; clears the handshake state and ends any line.
// Top level of the midpoint line rasterizer; depends on mlr_pkg, mlr_front,
// mlr_queue and mlr_back.
`timescale 1ns / 1ps

module midpoint_line_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mlr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output mlr_pkg::out_item_t result
);
    import mlr_pkg::*;

    logic      front_valid;
    logic      front_ready;
    line_cmd_t front_cmd;
    logic      queue_valid;
    logic      queue_ready;
    line_cmd_t queue_cmd;

    // Classification and line setup.
    mlr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    // Decoupling queue.
    mlr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    // Pixel stepping and output register.
    mlr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_valid),
        .cmd_ready    (queue_ready),
        .cmd          (queue_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
